// File: hdl/mkde_pkg.sv
// Shared types, codes and constants for the matrix keypad debounce and event block.
package mkde_pkg;

    localparam int KEY_BITS   = 16;
    localparam int TABLE_ROWS = 4;
    localparam int TABLE_COLS = 4;

    localparam logic [15:0] DEBOUNCE_RESET  = 16'd15;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [15:0] SHORT_MAX_TICKS = 16'd1000;
    localparam logic [6:0]  REPEAT_TICKS    = 7'd100;

    localparam logic [1:0] EV_PRESS       = 2'd0;
    localparam logic [1:0] EV_SHORT_PRESS = 2'd1;
    localparam logic [1:0] EV_RELEASE     = 2'd2;

    localparam logic [7:0] NO_KEY = 8'd0;

    localparam logic [7:0] KEY_TABLE [TABLE_ROWS*TABLE_COLS] = '{
        "1", "2", "3", "A",
        "4", "5", "6", "B",
        "7", "8", "9", "C",
        "*", "0", "#", "D"
    };

    typedef struct packed {
        logic [1:0] event_kind;
        logic       is_repeat;
        logic [7:0] key_value;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } events_t;

endpackage

// File: hdl/mkde_if.sv
// Handshake channel interfaces for key ticks, key events and the debounce register.
interface mkde_key_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_lines;

    modport source (output valid, output key_lines, input ready);
    modport sink (input valid, input key_lines, output ready);
endinterface

interface mkde_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic       is_repeat;
    logic [7:0] key_value;
    logic       last_of_run;

    modport source (output valid, output event_kind, output is_repeat, output key_value,
                    output last_of_run, input ready);
    modport sink (input valid, input event_kind, input is_repeat, input key_value,
                  input last_of_run, output ready);
endinterface

interface mkde_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/matrix_keypad_debounce_events.sv
// Top level of the matrix keypad scanner with debounce and key events.
//
//  Channel    Role  Payload
//  key_in     sink  key_lines: one tick of raw matrix levels, active low
//  event_out  src   event_kind, is_repeat, key_value, last_of_run
//  cfg        sink  data: debounce_ticks
//
// A tick is scanned on entry and held in an input register; once the queue has room it updates
// the debounce and hold state and pushes zero, one or two events into a four-entry queue.
// A tick is accepted every cycle while the queue has room for two events; the event port
// sends one event per cycle while ready is high, so a short press and release go in turn.
// Reset sets debounce_ticks to 15 and clears all key state; no clearing pass is needed.
// A stalled event port backs up into the queue and then holds key_in.ready low.
module matrix_keypad_debounce_events #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    mkde_key_if.sink      key_in,
    mkde_event_if.source  event_out,
    mkde_cfg_if.sink      cfg
);
    import mkde_pkg::*;

    logic [15:0] debounce_reg;
    logic [7:0]  raw_key_reg;
    logic        raw_valid_reg;
    logic [7:0]  scanned_key;
    logic        room;
    logic        fire;
    events_t     events;

    assign cfg.ready    = 1'b1;
    assign fire         = raw_valid_reg && room;
    assign key_in.ready = !raw_valid_reg || fire;

    mkde_scan #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_scan (
        .key_lines (key_in.key_lines),
        .key_value (scanned_key)
    );

    mkde_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .raw_key        (raw_key_reg),
        .debounce_ticks (debounce_reg),
        .events         (events)
    );

    mkde_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .events    (events),
        .room      (room),
        .event_out (event_out)
    );

    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
        begin
            raw_key_reg <= scanned_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg <= 1'b0;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else
        begin
            if (key_in.ready)
            begin
                raw_valid_reg <= key_in.valid;
            end
            if (cfg.valid && cfg.ready)
            begin
                debounce_reg <= cfg.data;
            end
        end
    end

endmodule

// File: hdl/mkde_scan.sv
// Priority scan of the key matrix levels into the ASCII code of the first closed key.
module mkde_scan #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic [15:0] key_lines,
    output logic [7:0]  key_value
);
    import mkde_pkg::*;

    localparam int SCAN_ROWS = (ROWS < TABLE_ROWS) ? ROWS : TABLE_ROWS;
    localparam int SCAN_COLS = (COLS < TABLE_COLS) ? COLS : TABLE_COLS;

    // Scanning backward lets the first closed key in row-major order win.
    always_comb
    begin
        int bit_idx;
        key_value = NO_KEY;
        for (int r = SCAN_ROWS - 1; r >= 0; r--)
        begin
            for (int c = SCAN_COLS - 1; c >= 0; c--)
            begin
                bit_idx = r * COLS + c;
                if (bit_idx < KEY_BITS && !key_lines[bit_idx[3:0]])
                begin
                    key_value = KEY_TABLE[4'(r * TABLE_COLS + c)];
                end
            end
        end
    end

endmodule

// File: hdl/mkde_tracker.sv
// Debounce, hold timing and event generation for one scanned key per tick.
module mkde_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            raw_key,
    input  logic [15:0]           debounce_ticks,
    output mkde_pkg::events_t     events
);
    import mkde_pkg::*;

    logic [7:0]  candidate_reg, candidate_next;
    logic        settling_reg, settling_next;
    logic [15:0] settle_count_reg, settle_count_next;
    logic [7:0]  stable_reg, stable_next;
    logic [7:0]  previous_reg;
    logic        held_reg, held_next;
    logic [15:0] hold_age_reg, hold_age_next;
    logic [6:0]  repeat_reg, repeat_next;

    logic [6:0]  repeat_inc;
    logic        settle_pending;

    always_comb
    begin
        candidate_next    = candidate_reg;
        settle_count_next = settle_count_reg;
        settle_pending    = settling_reg;
        if (raw_key != candidate_reg)
        begin
            candidate_next    = raw_key;
            settle_pending    = 1'b1;
            settle_count_next = '0;
        end
        else if (settling_reg && settle_count_reg != COUNT_MAX)
        begin
            settle_count_next = settle_count_reg + 16'd1;
        end

        stable_next   = stable_reg;
        settling_next = settle_pending;
        if (settle_pending && settle_count_next >= debounce_ticks)
        begin
            stable_next   = candidate_next;
            settling_next = 1'b0;
        end

        hold_age_next = hold_age_reg;
        if (held_reg && hold_age_reg != COUNT_MAX)
        begin
            hold_age_next = hold_age_reg + 16'd1;
        end

        held_next   = held_reg;
        repeat_next = repeat_reg;
        repeat_inc  = repeat_reg + 7'd1;
        events      = '0;

        if (stable_next != previous_reg)
        begin
            repeat_next = '0;
            if (stable_next != NO_KEY)
            begin
                held_next     = 1'b1;
                hold_age_next = '0;
                events.count  = 2'd1;
                events.first  = '{EV_PRESS, 1'b0, stable_next, 1'b1};
            end
            else
            begin
                held_next = 1'b0;
                if (hold_age_next <= SHORT_MAX_TICKS)
                begin
                    events.count  = 2'd2;
                    events.first  = '{EV_SHORT_PRESS, 1'b0, previous_reg, 1'b0};
                    events.second = '{EV_RELEASE, 1'b0, previous_reg, 1'b1};
                end
                else
                begin
                    events.count = 2'd1;
                    events.first = '{EV_RELEASE, 1'b0, previous_reg, 1'b1};
                end
            end
        end
        else if (held_reg)
        begin
            repeat_next = repeat_inc;
            if (repeat_inc >= REPEAT_TICKS)
            begin
                repeat_next  = '0;
                events.count = 2'd1;
                events.first = '{EV_PRESS, 1'b1, stable_next, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg    <= '0;
            settling_reg     <= 1'b0;
            settle_count_reg <= '0;
            stable_reg       <= '0;
            previous_reg     <= '0;
            held_reg         <= 1'b0;
            hold_age_reg     <= '0;
            repeat_reg       <= '0;
        end
        else if (fire)
        begin
            candidate_reg    <= candidate_next;
            settling_reg     <= settling_next;
            settle_count_reg <= settle_count_next;
            stable_reg       <= stable_next;
            previous_reg     <= stable_next;
            held_reg         <= held_next;
            hold_age_reg     <= hold_age_next;
            repeat_reg       <= repeat_next;
        end
    end

endmodule

// File: hdl/mkde_result_fifo.sv
// Four-entry result queue that takes up to two events per cycle and sends one.
module mkde_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mkde_pkg::events_t     events,
    output logic                  room,
    mkde_event_if.source          event_out
);
    import mkde_pkg::*;

    result_t     entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  push_n;
    logic        pop;
    result_t     head;

    assign room   = count_reg <= 3'd2;
    assign push_n = push ? events.count : 2'd0;
    assign pop    = event_out.valid && event_out.ready;
    assign head   = entry_reg[rd_ptr_reg];

    assign event_out.valid       = count_reg != 3'd0;
    assign event_out.event_kind  = head.event_kind;
    assign event_out.is_repeat   = head.is_repeat;
    assign event_out.key_value   = head.key_value;
    assign event_out.last_of_run = head.last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= events.first;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= events.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: tb/sv/tb_matrix_keypad_debounce_events.sv
// Self-checking testbench for the matrix keypad debounce and key event block.
`timescale 1ns / 1ps

module tb_matrix_keypad_debounce_events;
    import mkde_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 20;
    localparam int unsigned LIMIT_CYCLES  = 3000000;
    localparam int unsigned RANDOM_TICKS  = 750;
    localparam int          PHASES        = 5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mkde_key_if   key_ch ();
    mkde_event_if event_ch ();
    mkde_cfg_if   cfg_ch ();

    matrix_keypad_debounce_events dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (key_ch),
        .event_out (event_ch),
        .cfg       (cfg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    logic [15:0] debounce_setting   = DEBOUNCE_RESET;
    logic [7:0]  raw_candidate      = NO_KEY;
    logic        is_settling        = 1'b0;
    logic [15:0] settle_ticks       = '0;
    logic [7:0]  accepted_key       = NO_KEY;
    logic [7:0]  announced_key      = NO_KEY;
    logic        key_down           = 1'b0;
    logic [15:0] down_ticks         = '0;
    logic [15:0] ticks_since_repeat = '0;

    result_t     pending_events[$];
    int unsigned errors = 0;
    int unsigned ticks_sent = 0;
    int unsigned events_checked = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;
    bit          key_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d events still expected",
                     $time, pending_events.size());
            $display("matrix_keypad_debounce_events verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] decode_key(input logic [15:0] lines);
        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            for (int c = 0; c < TABLE_COLS; c++)
            begin
                if (lines[r * TABLE_COLS + c] == 1'b0)
                begin
                    return KEY_TABLE[r * TABLE_COLS + c];
                end
            end
        end
        return NO_KEY;
    endfunction

    function automatic logic [15:0] key_pattern(input int unsigned pos);
        logic [15:0] lines;
        lines = 16'($urandom) | ((16'd1 << pos) - 16'd1);
        lines[pos] = 1'b0;
        return lines;
    endfunction

    task automatic predict_tick(input logic [15:0] lines);
        logic [7:0] raw;
        result_t    run[$];
        raw = decode_key(lines);
        if (raw != raw_candidate)
        begin
            raw_candidate = raw;
            is_settling = 1'b1;
            settle_ticks = '0;
        end
        else if (is_settling && settle_ticks != COUNT_MAX)
        begin
            settle_ticks++;
        end
        if (is_settling && settle_ticks >= debounce_setting)
        begin
            accepted_key = raw_candidate;
            is_settling = 1'b0;
        end
        if (key_down && down_ticks != COUNT_MAX)
        begin
            down_ticks++;
        end
        if (accepted_key != announced_key)
        begin
            if (accepted_key != NO_KEY)
            begin
                key_down = 1'b1;
                down_ticks = '0;
                ticks_since_repeat = '0;
                run.push_back('{EV_PRESS, 1'b0, accepted_key, 1'b0});
            end
            else
            begin
                key_down = 1'b0;
                ticks_since_repeat = '0;
                if (down_ticks <= SHORT_MAX_TICKS)
                begin
                    run.push_back('{EV_SHORT_PRESS, 1'b0, announced_key, 1'b0});
                end
                run.push_back('{EV_RELEASE, 1'b0, announced_key, 1'b0});
            end
            announced_key = accepted_key;
        end
        else if (key_down)
        begin
            ticks_since_repeat++;
            if (ticks_since_repeat >= REPEAT_TICKS)
            begin
                ticks_since_repeat = '0;
                run.push_back('{EV_PRESS, 1'b1, accepted_key, 1'b0});
            end
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last_of_run = 1'b1;
        end
        foreach (run[i])
        begin
            pending_events.push_back(run[i]);
        end
    endtask

    task automatic send_tick(input logic [15:0] lines);
        int unsigned gap;
        gap = key_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key_lines <= lines;
        @(negedge clk);
        while (key_ch.ready !== 1'b1) @(negedge clk);
        @(posedge clk);
        predict_tick(lines);
        ticks_sent++;
    endtask

    task automatic send_repeated(input logic [15:0] lines, input int unsigned count);
        repeat (count) send_tick(lines);
    endtask

    task automatic wait_events_drained();
        key_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
    endtask

    task automatic write_debounce(input logic [15:0] value);
        wait_events_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(negedge clk);
        while (cfg_ch.ready !== 1'b1) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        debounce_setting = value;
        settings_used++;
    endtask

    task automatic test_reset_debounce();
        send_repeated(16'hFFDF, 2);
        send_tick(16'hFFFF);
        send_repeated(16'hFFDF, 16);
        send_repeated(16'hFFFF, 16);
    endtask

    task automatic test_directed_keys();
        write_debounce(16'd0);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        for (int k = 0; k < KEY_BITS; k++)
        begin
            send_tick(~(16'd1 << k));
        end
        send_tick(16'hFFFF);
    endtask

    task automatic test_random_sequences();
        int unsigned phase_start;
        int unsigned pos;
        int unsigned hold;
        logic [15:0] setting;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: setting = 16'd2;
                1: setting = 16'd0;
                2: setting = 16'd1;
                3: setting = 16'($urandom_range(3, 8));
                default: setting = 16'($urandom_range(0, 5));
            endcase
            write_debounce(setting);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < RANDOM_TICKS / PHASES)
            begin
                key_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
                pos = $urandom_range(0, KEY_BITS - 1);
                repeat ($urandom_range(0, 3)) send_tick(16'($urandom));
                if ($urandom_range(0, 4) == 0)
                begin
                    hold = debounce_setting + $urandom_range(90, 250);
                end
                else
                begin
                    hold = debounce_setting + $urandom_range(1, 30);
                end
                repeat (hold) send_tick(key_pattern(pos));
                if ($urandom_range(0, 4) != 0)
                begin
                    repeat ($urandom_range(0, 2)) send_tick(16'($urandom));
                    send_repeated(16'hFFFF, debounce_setting + $urandom_range(1, 10));
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    wait_events_drained();
                end
            end
        end
        key_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial
    begin : event_checker
        result_t     got;
        result_t     want;
        int unsigned stall;
        event_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                event_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            @(negedge clk);
            while (event_ch.valid !== 1'b1) @(negedge clk);
            got = '{event_ch.event_kind, event_ch.is_repeat, event_ch.key_value,
                    event_ch.last_of_run};
            @(posedge clk);
            events_checked++;
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected event, expected none, got %0d/%0d/%h/%0d",
                         $time, got.event_kind, got.is_repeat, got.key_value,
                         got.last_of_run);
            end
            else
            begin
                want = pending_events.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch, expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                             $time, want.event_kind, want.is_repeat, want.key_value,
                             want.last_of_run, got.event_kind, got.is_repeat,
                             got.key_value, got.last_of_run);
                end
            end
        end
    end

    initial
    begin
        key_ch.valid <= 1'b0;
        key_ch.key_lines <= 16'hFFFF;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= 16'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_debounce();
        test_directed_keys();
        test_random_sequences();
        wait_events_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d key ticks and checked %0d key events across %0d debounce settings,",
                 ticks_sent, events_checked, settings_used + 1);
        $display("including every key, key-to-key changes, hold repeats and random stalls.");
        if (errors == 0)
        begin
            $display("matrix_keypad_debounce_events verification clean");
        end
        else
        begin
            $display("matrix_keypad_debounce_events verification failed");
        end
        $finish;
    end

endmodule
